/* hw/rtl/heartbeat_monitor_latency_average_assert.svh */
// Assertion macros shared by the heartbeat monitor RTL.
// Expects signals named clk and arst_n in the scope where the macros are used.
`ifndef HEARTBEAT_MONITOR_LATENCY_AVERAGE_ASSERT_SVH
`define HEARTBEAT_MONITOR_LATENCY_AVERAGE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define HBMA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must follow from another one in the same cycle.
`define HBMA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hbma_pkg.sv */
// Shared widths, types and codes of the heartbeat monitor.
// Used by hbma_sdiv and heartbeat_monitor_latency_average; depends on nothing.
package hbma_pkg;

	localparam int NOW_W     = 48;  // tick count and latency width
	localparam int TIME_W    = 50;  // deadline width, room for now plus twice an interval
	localparam int SUM_W     = 56;  // running latency sum
	localparam int CFG_W     = 32;  // interval registers
	localparam int WIN_DEPTH = 16;  // latency window entries
	localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int BIT_W     = $clog2(SUM_W);
	localparam int ADDR_W    = 3;

	localparam logic [CFG_W-1:0] REQ_INTERVAL_RESET    = 32'd10000;
	localparam logic [CFG_W-1:0] PERMIT_INTERVAL_RESET = 32'd30000;

	// Register select, taken from paddr[2].
	localparam logic REG_REQUEST_INTERVAL = 1'b0;
	localparam logic REG_PERMIT_INTERVAL  = 1'b1;

	typedef logic [NOW_W-1:0]  stamp_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [CFG_W-1:0]  cfg_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WIN_AW-1:0] idx_t;
	typedef logic [BIT_W-1:0]  bit_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_REPLY = 2'd1,
		CMD_RESET = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hw/rtl/hbma_sdiv.sv */
// Bit-serial restoring divider: running latency sum over the window fill count.
// Depends on hbma_pkg for widths and the status struct.
module hbma_sdiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hbma_pkg::sum_t      dividend,
	input  hbma_pkg::cnt_t      divisor,
	output hbma_pkg::div_stat_t stat,
	output hbma_pkg::stamp_t    quotient
);

	logic                       busy_q;
	logic                       done_q;
	hbma_pkg::bit_t             step_q;
	hbma_pkg::sum_t             dvd_q;
	hbma_pkg::cnt_t             rem_q;
	hbma_pkg::stamp_t           quo_q;
	logic [hbma_pkg::CNT_W:0]   trial;
	logic [hbma_pkg::CNT_W:0]   rem_nxt;
	logic                       fits;

	// One quotient bit per cycle, dividend consumed from its top bit.
	always_comb begin
		trial   = {rem_q, dvd_q[hbma_pkg::SUM_W-1]};
		fits    = (trial >= {1'b0, divisor});
		rem_nxt = fits ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q &&
				(step_q == hbma_pkg::bit_t'(hbma_pkg::SUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == hbma_pkg::bit_t'(hbma_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[hbma_pkg::SUM_W-2:0], 1'b0};
			rem_q <= rem_nxt[hbma_pkg::CNT_W-1:0];
			quo_q <= {quo_q[hbma_pkg::NOW_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* hw/rtl/heartbeat_monitor_latency_average.sv */
// Heartbeat monitor top level; uses hbma_pkg, hbma_sdiv and the assertion .svh.
// A tick or a session reset runs the serial time pass over the 50-bit deadlines; a reply
// reads the window, runs the serial pass over the 56-bit sum and then the divider; the
// unused command code goes straight to the result. One request at a time: s_tready is
// high only while idle, so a new request waits until the last result is loaded. Asynchronous reset (arst_n low)
// loads interval defaults and zeroes deadlines and window; the latency memory is not reset.
module heartbeat_monitor_latency_average (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input requests.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now_time [47:0], echoed_time [95:48], connected [96], session_ready [97], zero pad
	input  logic [103:0]                  s_tdata,
	// command [1:0]
	input  logic [1:0]                    s_tuser,
	// Results.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// send_request [0], request_stamp [48:1], disconnect [49], average_latency [97:50], pad
	output logic [103:0]                  m_tdata,
	// Configuration.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbma_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TIME,
		S_RD,
		S_SUM,
		S_DIV,
		S_DONE
	} state_t;

	// Field view of the input request.
	hbma_pkg::cmd_t   command;
	hbma_pkg::stamp_t now_time;
	hbma_pkg::stamp_t echoed_time;
	logic             connected;
	logic             session_ready;

	assign command       = hbma_pkg::cmd_t'(s_tuser);
	assign now_time      = s_tdata[47:0];
	assign echoed_time   = s_tdata[95:48];
	assign connected     = s_tdata[96];
	assign session_ready = s_tdata[97];

	state_t             state_q;

	// Configuration registers.
	hbma_pkg::cfg_t     req_int_q;
	hbma_pkg::cfg_t     perm_int_q;

	// Latched request.
	hbma_pkg::cmd_t     cmd_q;
	hbma_pkg::stamp_t   now_q;
	logic               conn_q;
	logic               rdy_q;

	// Architectural state.
	hbma_pkg::time_t    ls_q;     // last heartbeat time (liveness deadline base)
	hbma_pkg::time_t    nr_q;     // next request time
	hbma_pkg::idx_t     head_q;
	hbma_pkg::cnt_t     cnt_q;
	hbma_pkg::sum_t     sum_q;
	hbma_pkg::stamp_t   mean_q;

	// Serial work registers; wa, wb, wc and, for its 48 bits, lat shift right one bit per cycle in a pass.
	hbma_pkg::time_t    wa_q;
	hbma_pkg::time_t    wb_q;
	hbma_pkg::time_t    wc_q;
	hbma_pkg::stamp_t   lat_q;
	hbma_pkg::bit_t     bit_q;
	logic               c1_q;
	logic               c2_q;
	logic               c3_q;
	logic               gt_q;     // now is later than last seen plus permit
	logic               lt_q;     // now is earlier than the next request time
	logic               div_go_q;

	// Result register.
	logic               m_valid_q;
	logic               send_q;
	hbma_pkg::stamp_t   stamp_q;
	logic               disc_q;
	hbma_pkg::stamp_t   avg_q;

	// Latency window memory.
	hbma_pkg::stamp_t   win_mem [hbma_pkg::WIN_DEPTH];
	hbma_pkg::stamp_t   mem_rd_q;
	logic               mem_we;
	hbma_pkg::idx_t     mem_wa;

	hbma_pkg::div_stat_t div_stat;
	hbma_pkg::stamp_t    div_quot;

	// Bit-level datapath signals.
	logic               n_b, p_b, r_b, l_b, x_b;
	logic               a_b, s1_b, s2_b;
	logic               lat_b, d_b, t_b;
	logic               lat_live;
	logic               full;
	logic [hbma_pkg::WIN_AW:0] slot_ext;
	hbma_pkg::idx_t     slot;
	hbma_pkg::idx_t     head_nxt;
	logic               tick_hit;
	logic               tick_upd;
	logic               cfg_wr;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, avg_q, disc_q, stamp_q, send_q};

	// The configuration port never stalls; paddr[2] picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == hbma_pkg::REG_PERMIT_INTERVAL) ? perm_int_q : req_int_q;

	// Window bookkeeping. A full window overwrites its oldest entry at the head.
	assign full     = (cnt_q == hbma_pkg::cnt_t'(hbma_pkg::WIN_DEPTH));
	assign slot_ext = {1'b0, head_q} + {1'b0, cnt_q[hbma_pkg::WIN_AW-1:0]};
	assign slot     = (slot_ext >= (hbma_pkg::WIN_AW + 1)'(hbma_pkg::WIN_DEPTH)) ?
		hbma_pkg::idx_t'(slot_ext - (hbma_pkg::WIN_AW + 1)'(hbma_pkg::WIN_DEPTH)) :
		slot_ext[hbma_pkg::WIN_AW-1:0];
	assign head_nxt = (head_q == hbma_pkg::idx_t'(hbma_pkg::WIN_DEPTH - 1)) ? '0 :
		head_q + 1'b1;
	assign mem_we   = (state_q == S_SUM) &&
		(bit_q == hbma_pkg::bit_t'(hbma_pkg::SUM_W - 1));
	assign mem_wa   = full ? head_q : slot;

	// Serial datapath. During the time pass the streams are: wa now, wb the permit term,
	// wc the request term. During the sum pass: wa now, wb the echoed time, wc the entry
	// that leaves the window (zero while the window is filling).
	always_comb begin
		n_b = wa_q[0];
		p_b = wb_q[0];
		r_b = wc_q[0];
		l_b = ls_q[0];
		x_b = nr_q[0];
		// Tick: last seen plus permit. Reset: now plus twice the permit.
		a_b  = l_b ^ p_b ^ c1_q;
		s1_b = n_b ^ p_b ^ c1_q;
		// Now plus the request term, for both tick and reset.
		s2_b = n_b ^ r_b ^ c2_q;
		// Latency is now minus echo modulo 2^48: bits above that are dropped.
		lat_live = (bit_q < hbma_pkg::bit_t'(hbma_pkg::NOW_W));
		lat_b    = lat_live & (n_b ^ p_b ^ c1_q);
		// Sum minus the leaving entry, then plus the new latency.
		d_b = sum_q[0] ^ r_b ^ c2_q;
		t_b = d_b ^ lat_b ^ c3_q;
		// Decisions of a tick, read once the time pass has finished.
		tick_hit = conn_q && rdy_q && gt_q;
		tick_upd = conn_q && !tick_hit && !lt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_int_q  <= hbma_pkg::REQ_INTERVAL_RESET;
			perm_int_q <= hbma_pkg::PERMIT_INTERVAL_RESET;
			cmd_q      <= hbma_pkg::CMD_NONE;
			now_q      <= '0;
			conn_q     <= 1'b0;
			rdy_q      <= 1'b0;
			ls_q       <= '0;
			nr_q       <= '0;
			head_q     <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			mean_q     <= '0;
			wa_q       <= '0;
			wb_q       <= '0;
			wc_q       <= '0;
			lat_q      <= '0;
			bit_q      <= '0;
			c1_q       <= 1'b0;
			c2_q       <= 1'b0;
			c3_q       <= 1'b0;
			gt_q       <= 1'b0;
			lt_q       <= 1'b0;
			div_go_q   <= 1'b0;
			m_valid_q  <= 1'b0;
			send_q     <= 1'b0;
			stamp_q    <= '0;
			disc_q     <= 1'b0;
			avg_q      <= '0;
		end else begin
			// The divider starts right after the last bit of the sum pass.
			div_go_q <= mem_we;
			// A taken result frees the output register unless a new one is loaded.
			if (m_valid_q && m_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				if (paddr[2] == hbma_pkg::REG_PERMIT_INTERVAL) begin
					perm_int_q <= pwdata;
				end else begin
					req_int_q <= pwdata;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q  <= command;
						now_q  <= now_time;
						conn_q <= connected;
						rdy_q  <= session_ready;
						wa_q   <= hbma_pkg::time_t'(now_time);
						bit_q  <= '0;
						c1_q   <= 1'b0;
						c2_q   <= 1'b0;
						c3_q   <= 1'b0;
						gt_q   <= 1'b0;
						lt_q   <= 1'b0;
						unique case (command)
							hbma_pkg::CMD_TICK: begin
								wb_q    <= hbma_pkg::time_t'(perm_int_q);
								wc_q    <= hbma_pkg::time_t'(req_int_q);
								state_q <= S_TIME;
							end
							hbma_pkg::CMD_RESET: begin
								wb_q    <= hbma_pkg::time_t'({perm_int_q, 1'b0});
								wc_q    <= hbma_pkg::time_t'({req_int_q, 1'b0});
								state_q <= S_TIME;
							end
							hbma_pkg::CMD_REPLY: begin
								wb_q    <= hbma_pkg::time_t'(echoed_time);
								state_q <= S_RD;
							end
							hbma_pkg::CMD_NONE: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_TIME: begin
					wb_q  <= {1'b0, wb_q[hbma_pkg::TIME_W-1:1]};
					wc_q  <= {1'b0, wc_q[hbma_pkg::TIME_W-1:1]};
					bit_q <= bit_q + 1'b1;
					if (cmd_q == hbma_pkg::CMD_RESET) begin
						// Both deadlines are rebuilt in place, one bit per cycle.
						c1_q <= (n_b & p_b) | (c1_q & (n_b ^ p_b));
						c2_q <= (n_b & r_b) | (c2_q & (n_b ^ r_b));
						ls_q <= {s1_b, ls_q[hbma_pkg::TIME_W-1:1]};
						nr_q <= {s2_b, nr_q[hbma_pkg::TIME_W-1:1]};
						wa_q <= {1'b0, wa_q[hbma_pkg::TIME_W-1:1]};
					end else begin
						// Deadlines rotate back to their place; the candidate next
						// request time collects in wa behind the bits of now.
						c1_q <= (l_b & p_b) | (c1_q & (l_b ^ p_b));
						c2_q <= (n_b & r_b) | (c2_q & (n_b ^ r_b));
						if (n_b != a_b) begin
							gt_q <= n_b;
						end
						if (n_b != x_b) begin
							lt_q <= x_b;
						end
						ls_q <= {l_b, ls_q[hbma_pkg::TIME_W-1:1]};
						nr_q <= {x_b, nr_q[hbma_pkg::TIME_W-1:1]};
						wa_q <= {s2_b, wa_q[hbma_pkg::TIME_W-1:1]};
					end
					if (bit_q == hbma_pkg::bit_t'(hbma_pkg::TIME_W - 1)) begin
						state_q <= S_DONE;
					end
				end

				S_RD: begin
					// mem_rd_q holds the head entry: the head has not moved since idle.
					wc_q    <= full ? hbma_pkg::time_t'(mem_rd_q) : '0;
					ls_q    <= hbma_pkg::time_t'(now_q);
					bit_q   <= '0;
					state_q <= S_SUM;
				end

				S_SUM: begin
					wa_q  <= {1'b0, wa_q[hbma_pkg::TIME_W-1:1]};
					wb_q  <= {1'b0, wb_q[hbma_pkg::TIME_W-1:1]};
					wc_q  <= {1'b0, wc_q[hbma_pkg::TIME_W-1:1]};
					bit_q <= bit_q + 1'b1;
					c1_q  <= (~n_b & p_b) | (~(n_b ^ p_b) & c1_q);
					c2_q  <= (~sum_q[0] & r_b) | (~(sum_q[0] ^ r_b) & c2_q);
					c3_q  <= (d_b & lat_b) | (c3_q & (d_b ^ lat_b));
					sum_q <= {t_b, sum_q[hbma_pkg::SUM_W-1:1]};
					if (lat_live) begin
						lat_q <= {lat_b, lat_q[hbma_pkg::NOW_W-1:1]};
					end
					if (bit_q == hbma_pkg::bit_t'(hbma_pkg::SUM_W - 1)) begin
						// The latency is stored in this cycle; the count moves
						// before the divider samples it.
						if (full) begin
							head_q <= head_nxt;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q  <= S_DIV;
					end
				end

				S_DIV: begin
					if (div_stat.done) begin
						mean_q  <= div_quot;
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						send_q    <= (cmd_q == hbma_pkg::CMD_TICK) && tick_upd && rdy_q;
						stamp_q   <= ((cmd_q == hbma_pkg::CMD_TICK) && tick_upd && rdy_q) ?
							now_q : '0;
						disc_q    <= (cmd_q == hbma_pkg::CMD_TICK) && tick_hit;
						avg_q     <= (cmd_q == hbma_pkg::CMD_RESET) ? '0 : mean_q;
						state_q   <= S_IDLE;
						unique case (cmd_q)
							hbma_pkg::CMD_TICK: begin
								if (tick_upd) begin
									nr_q <= wa_q;
								end
							end
							hbma_pkg::CMD_RESET: begin
								head_q <= '0;
								cnt_q  <= '0;
								sum_q  <= '0;
								mean_q <= '0;
							end
							hbma_pkg::CMD_REPLY, hbma_pkg::CMD_NONE: begin
							end
						endcase
					end
				end
			endcase
		end
	end

	// Window memory: one write port, one registered read port at the head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_wa] <= lat_q;
		end
		mem_rd_q <= win_mem[head_q];
	end

	hbma_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// The window never holds more latencies than it has entries.
	`include "heartbeat_monitor_latency_average_assert.svh"
	`HBMA_ASSERT_ALWAYS(a_cnt, cnt_q <= hbma_pkg::cnt_t'(hbma_pkg::WIN_DEPTH), "count overflow")
	// A tick either times the session out or asks for a heartbeat, never both.
	`HBMA_ASSERT_IMPLY(a_send_disc, m_valid_q, !(send_q && disc_q), "send with disconnect")
	// The divider only runs while the sequencer waits for the mean.
	`HBMA_ASSERT_IMPLY(a_div_phase, |div_stat, state_q == S_DIV, "divider out of phase")

endmodule
